[hdl/cncf_pkg.sv]
// Package for the console number and character formatter.
// Holds the item structs, command codes, ASCII constants and the controller/datapath
// interface types. Depends on nothing.
package cncf_pkg;

  localparam logic [1:0] CMD_RAW = 2'd0;
  localparam logic [1:0] CMD_HEX = 2'd1;
  localparam logic [1:0] CMD_DEC = 2'd2;

  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_X    = 8'h78;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    SEL_CR,
    SEL_RAW,
    SEL_ZERO,
    SEL_X,
    SEL_DIGIT
  } char_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      dec_load;
    logic      scan_step;
    logic      out_load;
    char_sel_t out_sel;
    logic      out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_lf;
    logic conv_last;
    logic digit_emit;
    logic rem_one;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h61;
      4'hB: c = 8'h62;
      4'hC: c = 8'h63;
      4'hD: c = 8'h64;
      4'hE: c = 8'h65;
      4'hF: c = 8'h66;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

[hdl/cncf_ctrl.sv]
// Sequencing state machine of the formatter.
// Drives dp_cmd_t commands into cncf_datapath and reads its dp_status_t; uses cncf_pkg.
module cncf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  input  cncf_pkg::dp_status_t status,
  output cncf_pkg::dp_cmd_t    cmd
);
  import cncf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CR    = 7'b0000010,
    S_RAW   = 7'b0000100,
    S_HEX0  = 7'b0001000,
    S_HEXX  = 7'b0010000,
    S_CONV  = 7'b0100000,
    S_DLOAD = 7'b1000000
  } state_t;

  // The digit scan runs as a small state machine of its own beside the main one.
  typedef enum logic [1:0] {
    SCAN_OFF = 2'b01,
    SCAN_ON  = 2'b10
  } scan_t;

  state_t state, state_next;
  scan_t  scan, scan_next;

  assign in_stall = (state != S_IDLE) || (scan == SCAN_ON);

  always_comb begin
    state_next    = state;
    scan_next     = scan;
    cmd           = '0;
    cmd.out_sel   = SEL_DIGIT;
    if (scan == SCAN_ON) begin
      if (status.digit_emit) begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = SEL_DIGIT;
          cmd.out_last  = status.rem_one;
          cmd.scan_step = 1'b1;
          if (status.rem_one) begin
            scan_next = SCAN_OFF;
          end
        end
      end else begin
        // Leading zero: drop it without using the output.
        cmd.scan_step = 1'b1;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.load = 1'b1;
            case (in_cmd)
              CMD_RAW: state_next = status.in_lf ? S_CR : S_RAW;
              CMD_HEX: state_next = S_HEX0;
              CMD_DEC: state_next = S_CONV;
              default: state_next = S_IDLE;
            endcase
          end
        end
        S_CR: begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_CR;
            state_next   = S_RAW;
          end
        end
        S_RAW: begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_RAW;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end
        S_HEX0: begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_ZERO;
            state_next   = S_HEXX;
          end
        end
        S_HEXX: begin
          if (status.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_X;
            state_next   = S_IDLE;
            scan_next    = SCAN_ON;
          end
        end
        S_CONV: begin
          cmd.conv_step = 1'b1;
          if (status.conv_last) begin
            state_next = S_DLOAD;
          end
        end
        S_DLOAD: begin
          cmd.dec_load = 1'b1;
          state_next   = S_IDLE;
          scan_next    = SCAN_ON;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan  <= SCAN_OFF;
    end else begin
      state <= state_next;
      scan  <= scan_next;
    end
  end

endmodule

[hdl/cncf_datapath.sv]
// Datapath of the formatter: value shifter, double-dabble BCD converter, digit scan
// register and the output register. Commanded by cncf_ctrl; uses cncf_pkg.
module cncf_datapath #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cncf_pkg::in_item_t   in_item,
  input  logic                 out_stall,
  output logic                 out_valid,
  output cncf_pkg::out_item_t  out_item,
  input  cncf_pkg::dp_cmd_t    cmd,
  output cncf_pkg::dp_status_t status
);
  import cncf_pkg::*;

  localparam int NIBBLES = (VALUE_WIDTH + 3) / 4;
  localparam int DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int LEN     = (DIGITS > NIBBLES) ? DIGITS : NIBBLES;
  localparam int HW      = NIBBLES * 4;
  localparam int BW      = DIGITS * 4;
  localparam int LW      = LEN * 4;
  localparam int RW      = $clog2(LEN + 1);
  localparam int CW      = $clog2(VALUE_WIDTH + 1);

  logic [7:0]             raw_char;
  logic [VALUE_WIDTH-1:0] vsh;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          bcd_adj;
  logic [CW-1:0]          conv_cnt;
  logic [LW-1:0]          dig;
  logic [RW-1:0]          rem;
  logic                   started;
  logic [3:0]             top;
  logic [HW-1:0]          hex_pad;
  logic                   top_nz;

  assign top     = dig[LW-1 -: 4];
  assign top_nz  = (top != 4'h0);
  assign hex_pad = HW'(in_item.value[VALUE_WIDTH-1:0]);

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  assign status.in_lf      = (in_item.char_code == ASCII_LF);
  assign status.conv_last  = (conv_cnt == CW'(1));
  assign status.rem_one    = (rem == RW'(1));
  assign status.digit_emit = started || top_nz || (rem == RW'(1));
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_char <= in_item.char_code;
      vsh      <= in_item.value[VALUE_WIDTH-1:0];
      bcd      <= '0;
      dig      <= LW'(hex_pad) << ((LEN - NIBBLES) * 4);
    end else begin
      if (cmd.conv_step) begin
        vsh <= vsh << 1;
        bcd <= {bcd_adj[BW-2:0], vsh[VALUE_WIDTH-1]};
      end
      if (cmd.dec_load) begin
        dig <= LW'(bcd) << ((LEN - DIGITS) * 4);
      end else if (cmd.scan_step) begin
        dig <= dig << 4;
      end
    end
    if (cmd.out_load) begin
      out_item.last <= cmd.out_last;
      case (cmd.out_sel)
        SEL_CR:    out_item.out_char <= ASCII_CR;
        SEL_RAW:   out_item.out_char <= raw_char;
        SEL_ZERO:  out_item.out_char <= ASCII_ZERO;
        SEL_X:     out_item.out_char <= ASCII_X;
        SEL_DIGIT: out_item.out_char <= digit_char(top);
        default:   out_item.out_char <= ASCII_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      conv_cnt  <= '0;
      rem       <= '0;
      started   <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        conv_cnt <= CW'(VALUE_WIDTH);
        rem      <= RW'(NIBBLES);
        started  <= 1'b0;
      end else begin
        if (cmd.conv_step) begin
          conv_cnt <= conv_cnt - CW'(1);
        end
        if (cmd.dec_load) begin
          rem     <= RW'(DIGITS);
          started <= 1'b0;
        end else if (cmd.scan_step) begin
          rem     <= rem - RW'(1);
          started <= started || top_nz;
        end
      end
    end
  end

endmodule

[hdl/console_number_char_formatter_top.sv]
// Console number and character formatter, one character item per cycle at most.
// A raw item gives its character, a line feed preceded by a carriage return; a hex item
// gives "0x" and then the nibbles of VALUE_WIDTH without leading zeros; a decimal item runs
// double-dabble over every value bit, loads the BCD digits and gives them without leading
// zeros; an unused selector is taken and dropped. A stalled output register holds a character
// back. A new item is taken in the cycle after the last character enters the output register.
// Synchronous reset clears the state machines and output valid; no memory to clear.
module console_number_char_formatter_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cncf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cncf_pkg::out_item_t out_item
);
  import cncf_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  cncf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  cncf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

endmodule

[hdl/cncf_checker.sv]
// Port-level checks for the formatter top level, attached by the bind at the end.
// Depends on cncf_pkg and console_number_char_formatter_top.
module cncf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input cncf_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input cncf_pkg::out_item_t out_item
);
  import cncf_pkg::*;

  // Nothing is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A stalled item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // A real command occupies the block in the next cycle.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.cmd == CMD_RAW || in_item.cmd == CMD_HEX ||
    in_item.cmd == CMD_DEC) |=> in_stall)
    else $error("block free right after taking a command");

  // Until a run's last character has been produced, no new item is taken.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("input taken in the middle of a run");

endmodule

bind console_number_char_formatter_top cncf_checker u_cncf_checker (.*);
